>>> rtl/point_in_shape_hit_test_defines.svh
`ifndef POINT_IN_SHAPE_HIT_TEST_DEFINES_SVH
`define POINT_IN_SHAPE_HIT_TEST_DEFINES_SVH

// Same-edge implication, sampled on clk, off while arst_n is low.
`define PISHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-edge implication, sampled on clk, off while arst_n is low.
`define PISHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pisht_pkg.sv
`default_nettype none

package pisht_pkg;

	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 5;

	typedef enum logic [2:0] {
		REG_RECT_LEFT     = 3'd0,
		REG_RECT_TOP      = 3'd1,
		REG_RECT_WIDTH    = 3'd2,
		REG_RECT_HEIGHT   = 3'd3,
		REG_SHAPE_KIND    = 3'd4,
		REG_CORNER_RADIUS = 3'd5,
		REG_INNER_RADIUS  = 3'd6,
		REG_OUTER_RADIUS  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		SHAPE_NONE   = 3'd0,
		SHAPE_RECT   = 3'd1,
		SHAPE_ROUND  = 3'd2,
		SHAPE_CIRCLE = 3'd3,
		SHAPE_RING   = 3'd4
	} shape_kind_t;

	typedef struct packed {
		logic en;
		logic need_rect;
		logic use_dist;
		logic inner_en;
	} shape_mode_t;

endpackage

`default_nettype wire

>>> rtl/point_in_shape_hit_test.sv
// Point-in-shape hit test.
// Point channel: point_valid / point_stall with point_x, point_y (signed fixed point).
// Result channel: hit_valid / hit_stall with hit. A transfer happens at a rising
// edge with valid high and stall low.
// Throughput: one point per clock while point_stall is low. Five pipeline registers
// (input capture, edge offsets, axis distance, squaring, radius compare); each point
// passes through them in that order before its result is shown on hit_valid and hit.
// A stalled result holds in the output stage; earlier stages keep filling until
// they are full, only then is point_stall raised. Nothing is lost or repeated.
// Shape registers sit on an APB-style port, byte address 4*index, pready tied
// high, reads return the stored value. Derived shape terms are registered from
// the registers, so a write is seen by points transferred after the write edge.
// Reset clears all shape registers to zero (shape none) and empties the pipeline.
`default_nettype none

module point_in_shape_hit_test
	import pisht_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CFG_ADDR_BITS-1:0]      paddr,
	input  logic [CFG_DATA_BITS-1:0]      pwdata,
	output logic [CFG_DATA_BITS-1:0]      prdata,
	output logic                          pready,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	output logic                          hit_valid,
	input  logic                          hit_stall,
	output logic                          hit
);

	localparam int C  = COORD_BITS;
	localparam int D  = COORD_BITS + 4;
	localparam int R  = COORD_BITS - 1;
	localparam int SQ = 2 * COORD_BITS;

	// registers
	logic [C-1:0] left_q, top_q;
	logic [R-1:0] width_q, height_q, corner_q, inner_q, outer_q;
	logic [2:0]   kind_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			kind_q   <= '0;
			corner_q <= '0;
			inner_q  <= '0;
			outer_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RECT_LEFT:     left_q   <= pwdata[C-1:0];
				REG_RECT_TOP:      top_q    <= pwdata[C-1:0];
				REG_RECT_WIDTH:    width_q  <= pwdata[R-1:0];
				REG_RECT_HEIGHT:   height_q <= pwdata[R-1:0];
				REG_SHAPE_KIND:    kind_q   <= pwdata[2:0];
				REG_CORNER_RADIUS: corner_q <= pwdata[R-1:0];
				REG_INNER_RADIUS:  inner_q  <= pwdata[R-1:0];
				REG_OUTER_RADIUS:  outer_q  <= pwdata[R-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_RECT_LEFT:     prdata = CFG_DATA_BITS'(left_q);
			REG_RECT_TOP:      prdata = CFG_DATA_BITS'(top_q);
			REG_RECT_WIDTH:    prdata = CFG_DATA_BITS'(width_q);
			REG_RECT_HEIGHT:   prdata = CFG_DATA_BITS'(height_q);
			REG_SHAPE_KIND:    prdata = CFG_DATA_BITS'(kind_q);
			REG_CORNER_RADIUS: prdata = CFG_DATA_BITS'(corner_q);
			REG_INNER_RADIUS:  prdata = CFG_DATA_BITS'(inner_q);
			REG_OUTER_RADIUS:  prdata = CFG_DATA_BITS'(outer_q);
			default:           prdata = '0;
		endcase
	end

	// derived shape terms, all at four times register scale
	logic signed [D-1:0] l4, t4, w4, h4, w2, h2, half4, cr4, ir4, or4;
	logic signed [D-1:0] rr, ro, ri, cx, cy;
	logic signed [D-1:0] lox, hix, loy, hiy;
	logic [R-1:0]        mn;
	logic [C-1:0]        rad_o, rad_i;
	shape_mode_t         mode;

	always_comb begin
		l4    = {{2{left_q[C-1]}}, left_q, 2'b00};
		t4    = {{2{top_q[C-1]}}, top_q, 2'b00};
		w4    = {3'b000, width_q, 2'b00};
		h4    = {3'b000, height_q, 2'b00};
		w2    = {4'b0000, width_q, 1'b0};
		h2    = {4'b0000, height_q, 1'b0};
		mn    = (width_q < height_q) ? width_q : height_q;
		half4 = {4'b0000, mn, 1'b0};
		cr4   = {3'b000, corner_q, 2'b00};
		ir4   = {3'b000, inner_q, 2'b00};
		or4   = {3'b000, outer_q, 2'b00};
		rr    = (cr4 > half4) ? half4 : cr4;
		ro    = (outer_q == '0 || or4 > half4) ? half4 : or4;
		if (inner_q == '0 && outer_q == '0)
			ri = ro >>> 1;
		else
			ri = (ir4 > ro) ? ro : ir4;
		cx = l4 + w2;
		cy = t4 + h2;

		mode  = '0;
		lox   = l4;
		hix   = l4 + w4;
		loy   = t4;
		hiy   = t4 + h4;
		rad_o = '0;
		rad_i = '0;
		case (shape_kind_t'(kind_q))
			SHAPE_RECT: begin
				mode.en        = 1'b1;
				mode.need_rect = 1'b1;
			end
			SHAPE_ROUND: begin
				mode.en        = 1'b1;
				mode.need_rect = 1'b1;
				mode.use_dist  = 1'b1;
				lox   = l4 + rr;
				hix   = l4 + w4 - rr;
				loy   = t4 + rr;
				hiy   = t4 + h4 - rr;
				rad_o = rr[C-1:0];
			end
			SHAPE_CIRCLE: begin
				mode.en       = 1'b1;
				mode.use_dist = 1'b1;
				lox   = cx;
				hix   = cx;
				loy   = cy;
				hiy   = cy;
				rad_o = ro[C-1:0];
			end
			SHAPE_RING: begin
				mode.en       = 1'b1;
				mode.use_dist = 1'b1;
				mode.inner_en = 1'b1;
				lox   = cx;
				hix   = cx;
				loy   = cy;
				hiy   = cy;
				rad_o = ro[C-1:0];
				rad_i = ri[C-1:0];
			end
			default: ;
		endcase
		if (width_q == '0 || height_q == '0)
			mode.en = 1'b0;
	end

	shape_mode_t         mode_q;
	logic signed [D-1:0] el_q, er_q, et_q, eb_q, lox_q, hix_q, loy_q, hiy_q;
	logic [C-1:0]        rado_q, radi_q;
	logic [SQ-1:0]       rsqo_q, rsqi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= '0;
		else
			mode_q <= mode;
	end

	always_ff @(posedge clk) begin
		el_q   <= l4;
		er_q   <= l4 + w4;
		et_q   <= t4;
		eb_q   <= t4 + h4;
		lox_q  <= lox;
		hix_q  <= hix;
		loy_q  <= loy;
		hiy_q  <= hiy;
		rado_q <= rad_o;
		radi_q <= rad_i;
		rsqo_q <= rado_q * rado_q;
		rsqi_q <= radi_q * radi_q;
	end

	// pipeline flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en1, en2, en3, en4, en5;

	assign en5         = !valid_s5 || !hit_stall;
	assign en4         = !valid_s4 || en5;
	assign en3         = !valid_s3 || en4;
	assign en2         = !valid_s2 || en3;
	assign en1         = !valid_s1 || en2;
	assign point_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= point_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	// s1: input capture
	logic signed [C-1:0] px_s1, py_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1 <= point_x;
			py_s1 <= point_y;
		end
	end

	// s2: offsets from the core region and rectangle test
	logic signed [D-1:0] px4, py4;
	logic signed [D-1:0] dlx_s2, dhx_s2, dly_s2, dhy_s2;
	logic                inr_s2;

	assign px4 = {{2{px_s1[C-1]}}, px_s1, 2'b00};
	assign py4 = {{2{py_s1[C-1]}}, py_s1, 2'b00};

	always_ff @(posedge clk) begin
		if (en2) begin
			dlx_s2 <= lox_q - px4;
			dhx_s2 <= px4 - hix_q;
			dly_s2 <= loy_q - py4;
			dhy_s2 <= py4 - hiy_q;
			inr_s2 <= px4 >= el_q && px4 <= er_q && py4 >= et_q && py4 <= eb_q;
		end
	end

	// s3: distance per axis, saturated beyond any radius
	function automatic logic [C-1:0] axis_dist(input logic signed [D-1:0] dlo,
			input logic signed [D-1:0] dhi);
		logic signed [D-1:0] d;
		if (dhi > 0)
			d = dhi;
		else if (dlo > 0)
			d = dlo;
		else
			d = '0;
		if (d[D-1:C] != '0)
			return '1;
		return d[C-1:0];
	endfunction

	logic [C-1:0] ax_s3, ay_s3;
	logic         inr_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			ax_s3  <= axis_dist(dlx_s2, dhx_s2);
			ay_s3  <= axis_dist(dly_s2, dhy_s2);
			inr_s3 <= inr_s2;
		end
	end

	// s4: squares
	logic [SQ-1:0] sqx_s4, sqy_s4;
	logic          inr_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			sqx_s4 <= ax_s3 * ax_s3;
			sqy_s4 <= ay_s3 * ay_s3;
			inr_s4 <= inr_s3;
		end
	end

	// s5: radius compare and result
	logic [SQ:0] dist_sq;
	logic        in_outer, in_hole, hit_d, hit_s5;

	assign dist_sq  = {1'b0, sqx_s4} + {1'b0, sqy_s4};
	assign in_outer = dist_sq <= {1'b0, rsqo_q};
	assign in_hole  = dist_sq < {1'b0, rsqi_q};
	assign hit_d    = mode_q.en && (!mode_q.need_rect || inr_s4) &&
		(!mode_q.use_dist || in_outer) && !(mode_q.inner_en && in_hole);

	always_ff @(posedge clk) begin
		if (en5)
			hit_s5 <= hit_d;
	end

	assign hit_valid = valid_s5;
	assign hit       = hit_s5;

endmodule

`default_nettype wire

>>> rtl/pisht_checker.sv
`default_nettype none
`include "point_in_shape_hit_test_defines.svh"

module pisht_checker (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	input logic point_stall,
	input logic hit_valid,
	input logic hit_stall,
	input logic hit
);

	`PISHT_ASSERT_NEXT(a_result_held, hit_valid && hit_stall, hit_valid && $stable(hit), "stalled result changed")
	`PISHT_ASSERT_NEXT(a_latency, point_valid && !point_stall ##1 !hit_stall ##1 !hit_stall ##1 !hit_stall ##1 !hit_stall, hit_valid, "result missing after pipeline latency")
	`PISHT_ASSERT_NOW(a_reset_empty, !$past(arst_n), !hit_valid, "result present straight after reset")

endmodule

bind point_in_shape_hit_test pisht_checker u_pisht_checker (.*);

`default_nettype wire

>>> sim/point_in_shape_hit_test_test.sv
`default_nettype none

module point_in_shape_hit_test_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pisht_pkg::*;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]        width;
		logic [14:0]        height;
		logic [2:0]         kind;
		logic [14:0]        corner;
		logic [14:0]        inner;
		logic [14:0]        outer;
	} shape_cfg_t;

	typedef struct packed {
		logic [3:0]         sel;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [1:0]         verdict;
	} dir_row_t;

	localparam logic [1:0] EXP_MISS    = 2'd0;
	localparam logic [1:0] EXP_HIT     = 2'd1;
	localparam logic [1:0] EXP_PREDICT = 2'd2;

	localparam logic [2:0] SHAPE_UNDEF = 3'd7;

	localparam int N_PHASES     = 24;
	localparam int PHASE_POINTS = 80;
	localparam int QUIET_FIRST  = 10;
	localparam int QUIET_LAST   = 14;

	localparam shape_cfg_t DIR_SHAPES [9] = '{
		'{16'sd0, 16'sd0, 15'd0, 15'd0, SHAPE_NONE, 15'd0, 15'd0, 15'd0},
		'{-16'sd100, -16'sd50, 15'd200, 15'd100, SHAPE_RECT, 15'd0, 15'd0, 15'd0},
		'{16'sd0, 16'sd0, 15'd100, 15'd60, SHAPE_ROUND, 15'd20, 15'd0, 15'd0},
		'{16'sh7fff, 16'sh7fff, 15'd32767, 15'd32767, SHAPE_RECT, 15'd0, 15'd0, 15'd0},
		'{16'sd0, 16'sd0, 15'd160, 15'd160, SHAPE_RING, 15'd0, 15'd0, 15'd0},
		'{16'sd0, 16'sd0, 15'd160, 15'd160, SHAPE_RING, 15'd0, 15'd100, 15'd30},
		'{16'sh8000, 16'sh8000, 15'd32767, 15'd32767, SHAPE_CIRCLE, 15'd0, 15'd0, 15'd0},
		'{16'sd0, 16'sd0, 15'd100, 15'd100, SHAPE_UNDEF, 15'd0, 15'd0, 15'd0},
		'{16'sd0, 16'sd0, 15'd0, 15'd100, SHAPE_RECT, 15'd0, 15'd0, 15'd0}
	};

	// sel 0 is the reset state, never written
	localparam dir_row_t DIR_ROWS [24] = '{
		'{4'd0, 16'sd0, 16'sd0, EXP_MISS},
		'{4'd0, 16'sh7fff, 16'sh8000, EXP_MISS},
		'{4'd1, -16'sd100, -16'sd50, EXP_HIT},
		'{4'd1, 16'sd100, 16'sd50, EXP_HIT},
		'{4'd1, 16'sd101, 16'sd0, EXP_MISS},
		'{4'd1, 16'sd0, 16'sd51, EXP_MISS},
		'{4'd1, 16'sh8000, 16'sh7fff, EXP_MISS},
		'{4'd2, 16'sd0, 16'sd0, EXP_MISS},
		'{4'd2, 16'sd0, 16'sd30, EXP_HIT},
		'{4'd2, 16'sd6, 16'sd6, EXP_PREDICT},
		'{4'd2, 16'sd5, 16'sd5, EXP_PREDICT},
		'{4'd2, 16'sd100, 16'sd60, EXP_MISS},
		'{4'd3, 16'sh7fff, 16'sh7fff, EXP_HIT},
		'{4'd3, 16'sd32766, 16'sh7fff, EXP_MISS},
		'{4'd4, 16'sd80, 16'sd80, EXP_MISS},
		'{4'd4, 16'sd120, 16'sd80, EXP_HIT},
		'{4'd4, 16'sd160, 16'sd80, EXP_HIT},
		'{4'd4, 16'sd161, 16'sd80, EXP_MISS},
		'{4'd5, 16'sd110, 16'sd80, EXP_HIT},
		'{4'd5, 16'sd109, 16'sd80, EXP_MISS},
		'{4'd6, -16'sd16384, -16'sd16384, EXP_PREDICT},
		'{4'd6, 16'sh8000, 16'sh8000, EXP_MISS},
		'{4'd7, 16'sd50, 16'sd50, EXP_MISS},
		'{4'd8, 16'sd0, 16'sd50, EXP_MISS}
	};

	localparam shape_cfg_t EXTREME_LOW =
		'{16'sh8000, 16'sh8000, 15'd32767, 15'd32767, SHAPE_RING, 15'd32767, 15'd32767, 15'd32767};
	localparam shape_cfg_t EXTREME_HIGH =
		'{16'sh7fff, 16'sh7fff, 15'd32767, 15'd32767, SHAPE_ROUND, 15'd32767, 15'd0, 15'd0};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [CFG_DATA_BITS-1:0] pwdata = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     point_valid = 1'b0;
	logic                     point_stall;
	logic signed [15:0]       point_x = '0;
	logic signed [15:0]       point_y = '0;
	logic                     hit_valid;
	logic                     hit_stall = 1'b0;
	logic                     hit;

	shape_cfg_t shape_regs = '0;
	bit         expected_hits [$];
	bit         noise_on = 1'b1;
	int         fail_count = 0;
	int         points_sent = 0;
	int         results_seen = 0;
	int         hits_seen = 0;
	int         shapes_loaded = 0;

	point_in_shape_hit_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point_x(point_x),
		.point_y(point_y),
		.hit_valid(hit_valid),
		.hit_stall(hit_stall),
		.hit(hit)
	);

	always #10 clk = ~clk;

	initial begin
		#2ms;
		$display("point_in_shape_hit_test_test failed");
		$finish;
	end

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// dx^2 + dy^2 against r^2, all at four times register scale
	function automatic bit within_dist(longint dx, longint dy, longint r, bit strict);
		longint ax, ay, room;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ax > r || ay > r)
			return 1'b0;
		room = r * r - ay * ay;
		return strict ? (ax * ax < room) : (ax * ax <= room);
	endfunction

	function automatic bit predict_hit(logic signed [15:0] x, logic signed [15:0] y);
		longint px, py, l, t, w, h, half, cx, cy, r, ro, ri, nx, ny;
		bit inrect, in_shape;
		px = 4 * longint'(x);
		py = 4 * longint'(y);
		l = 4 * longint'($signed(shape_regs.left));
		t = 4 * longint'($signed(shape_regs.top));
		w = 4 * longint'(shape_regs.width);
		h = 4 * longint'(shape_regs.height);
		half = (w < h ? w : h) / 2;
		cx = l + w / 2;
		cy = t + h / 2;
		inrect = px >= l && py >= t && px <= l + w && py <= t + h;
		in_shape = 1'b0;
		if (w > 0 && h > 0) begin
			case (shape_regs.kind)
				SHAPE_RECT: in_shape = inrect;
				SHAPE_ROUND: begin
					r = 4 * longint'(shape_regs.corner);
					if (r > half)
						r = half;
					if (!inrect)
						in_shape = 1'b0;
					else if (r == 0)
						in_shape = 1'b1;
					else begin
						nx = px < l + r ? l + r : (px > l + w - r ? l + w - r : px);
						ny = py < t + r ? t + r : (py > t + h - r ? t + h - r : py);
						in_shape = within_dist(px - nx, py - ny, r, 1'b0);
					end
				end
				SHAPE_CIRCLE, SHAPE_RING: begin
					ro = 4 * longint'(shape_regs.outer);
					ri = 4 * longint'(shape_regs.inner);
					if (ro == 0 || ro > half)
						ro = half;
					in_shape = within_dist(px - cx, py - cy, ro, 1'b0);
					if (shape_regs.kind == SHAPE_RING) begin
						if (shape_regs.inner == 0 && shape_regs.outer == 0)
							ri = ro / 2;
						else if (ri > ro)
							ri = ro;
						if (within_dist(px - cx, py - cy, ri, 1'b1))
							in_shape = 1'b0;
					end
				end
				default: in_shape = 1'b0;
			endcase
		end
		return in_shape;
	endfunction

	always @(posedge clk)
		hit_stall <= noise_on && ($urandom_range(99) < 11);

	always @(posedge clk) begin
		if (arst_n && hit_valid && !hit_stall) begin
			results_seen++;
			if (hit === 1'b1)
				hits_seen++;
			if (expected_hits.size() == 0)
				report_mismatch($sformatf("hit transfer with nothing pending, hit=%b", hit));
			else begin
				if (hit !== expected_hits[0])
					report_mismatch($sformatf("hit: expected %b, got %b",
						expected_hits[0], hit));
				void'(expected_hits.pop_front());
			end
		end
	end

	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
			logic [1:0] verdict);
		while (noise_on && $urandom_range(99) < 11) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		do @(posedge clk); while (point_stall !== 1'b0);
		expected_hits.push_back(verdict == EXP_PREDICT ? predict_hit(x, y) : verdict[0]);
		points_sent++;
	endtask

	// write, then read back in the following transfer
	task automatic write_reg(reg_idx_t idx, logic [31:0] val, int bits);
		logic [31:0] mask;
		mask = (32'd1 << bits) - 32'd1;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (val & mask))
			report_mismatch($sformatf("readback of %s: expected %h, got %h",
				idx.name(), val & mask, prdata & mask));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_shape(shape_cfg_t s);
		point_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		write_reg(REG_RECT_LEFT, {16'b0, s.left}, 16);
		write_reg(REG_RECT_TOP, {16'b0, s.top}, 16);
		write_reg(REG_RECT_WIDTH, {17'b0, s.width}, 15);
		write_reg(REG_RECT_HEIGHT, {17'b0, s.height}, 15);
		write_reg(REG_SHAPE_KIND, {29'b0, s.kind}, 3);
		write_reg(REG_CORNER_RADIUS, {17'b0, s.corner}, 15);
		write_reg(REG_INNER_RADIUS, {17'b0, s.inner}, 15);
		write_reg(REG_OUTER_RADIUS, {17'b0, s.outer}, 15);
		shape_regs = s;
		shapes_loaded++;
	endtask

	function automatic logic signed [15:0] pick_edge();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2, 3: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 1200)) - 600);
		endcase
	endfunction

	function automatic logic [14:0] pick_size();
		case ($urandom_range(11))
			0: return 15'd0;
			1: return 15'd32767;
			2: return 15'd1;
			default: return 15'($urandom_range(2, 500));
		endcase
	endfunction

	function automatic logic [14:0] pick_radius(int span);
		case ($urandom_range(5))
			0: return 15'd0;
			1: return 15'd32767;
			2: return 15'($urandom_range(32767));
			default: return 15'($urandom_range(0, span / 2 + 3));
		endcase
	endfunction

	function automatic logic signed [15:0] clip16(int v);
		if (v < -32768)
			return 16'sh8000;
		if (v > 32767)
			return 16'sh7fff;
		return 16'(v);
	endfunction

	task automatic pick_shape(output shape_cfg_t s);
		int span;
		s.kind = ($urandom_range(9) < 8) ? 3'($urandom_range(SHAPE_RECT, SHAPE_RING))
			: 3'($urandom_range(7));
		s.left = pick_edge();
		s.top = pick_edge();
		s.width = pick_size();
		s.height = pick_size();
		span = s.width < s.height ? int'(s.width) : int'(s.height);
		s.corner = pick_radius(span);
		s.inner = pick_radius(span);
		s.outer = pick_radius(span);
		if (s.kind == SHAPE_RING && $urandom_range(2) == 0) begin
			s.inner = '0;
			s.outer = '0;
		end
	endtask

	// mostly around the rectangle, some anywhere
	task automatic pick_point(output logic signed [15:0] x, output logic signed [15:0] y);
		int mx, my;
		if ($urandom_range(4) == 0) begin
			x = 16'($urandom);
			y = 16'($urandom);
		end else begin
			mx = int'(shape_regs.width) / 8 + 3;
			my = int'(shape_regs.height) / 8 + 3;
			x = clip16(int'($signed(shape_regs.left)) - mx
				+ int'($urandom_range(0, int'(shape_regs.width) + 2 * mx)));
			y = clip16(int'($signed(shape_regs.top)) - my
				+ int'($urandom_range(0, int'(shape_regs.height) + 2 * my)));
		end
	endtask

	initial begin
		shape_cfg_t s;
		logic signed [15:0] x, y;
		int cur;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = 0;
		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].sel != cur) begin
				cur = DIR_ROWS[i].sel;
				load_shape(DIR_SHAPES[cur]);
			end
			send_point(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].verdict);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			noise_on = !(p >= QUIET_FIRST && p <= QUIET_LAST);
			case (p)
				0: s = EXTREME_LOW;
				1: s = EXTREME_HIGH;
				default: pick_shape(s);
			endcase
			load_shape(s);
			repeat (PHASE_POINTS) begin
				pick_point(x, y);
				send_point(x, y, EXP_PREDICT);
			end
		end

		point_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("%0d points over %0d shape settings, %0d results checked, %0d of them hits",
			points_sent, shapes_loaded, results_seen, hits_seen);
		$display("mismatches: %0d", fail_count);
		if (fail_count == 0)
			$display("point_in_shape_hit_test_test passed");
		else
			$display("point_in_shape_hit_test_test failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> point_in_shape_hit_test.f
+incdir+rtl
rtl/pisht_pkg.sv
rtl/point_in_shape_hit_test.sv
rtl/pisht_checker.sv
sim/point_in_shape_hit_test_test.sv
